// ----- hdl/lpmr_pkg.sv -----
// ----------------------------------------------------------------------------
// lpmr_pkg
// Shared types, codes and helpers of the length-prefixed message ring.
// ----------------------------------------------------------------------------
package lpmr_pkg;

	localparam int RING_DEPTH = 1024;
	localparam int PTR_W      = $clog2(RING_DEPTH);
	localparam int SIZE_W     = $clog2(RING_DEPTH + 1);
	localparam int SUM_W      = ((SIZE_W > 9) ? SIZE_W : 9) + 1;
	localparam int CMP_W      = ((SIZE_W > 11) ? SIZE_W : 11) + 1;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_RING_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MSG   = 1'd1;

	localparam logic [SIZE_W-1:0] RESET_SIZE =
		SIZE_W'((RING_DEPTH < 1024) ? RING_DEPTH : 1024);
	localparam logic [7:0] RESET_MAX_MSG = 8'd255;

	localparam logic [1:0] OP_SEND_START = 2'd0;
	localparam logic [1:0] OP_SEND_BYTE  = 2'd1;
	localparam logic [1:0] OP_RECV_START = 2'd2;
	localparam logic [1:0] OP_RECV_BYTE  = 2'd3;

	localparam logic [2:0] STAT_OK        = 3'd0;
	localparam logic [2:0] STAT_NO_SPACE  = 3'd1;
	localparam logic [2:0] STAT_BAD_LEN   = 3'd2;
	localparam logic [2:0] STAT_EMPTY     = 3'd3;
	localparam logic [2:0] STAT_SEQUENCE  = 3'd4;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] message_length;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] read_value;
		logic       last_byte;
		logic       notify_sent;
		logic       notify_received;
	} out_item_t;

	typedef struct packed {
		logic accept;
		logic read_phase;
	} dp_cmd_t;

	typedef struct packed {
		logic rx_op;
	} dp_status_t;

	function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] ptr,
		input logic [SIZE_W-1:0] size);
		logic [SIZE_W:0] n;
		n = (SIZE_W + 1)'(ptr) + 1'b1;
		return (n >= (SIZE_W + 1)'(size)) ? '0 : PTR_W'(n);
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] val);
		logic [CMP_W-1:0] v;
		v = CMP_W'(val);
		if (v < CMP_W'(2)) begin
			v = CMP_W'(2);
		end
		if (v > CMP_W'(RING_DEPTH)) begin
			v = CMP_W'(RING_DEPTH);
		end
		return SIZE_W'(v);
	endfunction

endpackage

// ----- hdl/lpmr_ram.sv -----
// ----------------------------------------------------------------------------
// lpmr_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- hdl/lpmr_ctrl.sv -----
// ----------------------------------------------------------------------------
// lpmr_ctrl
// Handshake controller: input accept, ring read wait and result valid.
// ----------------------------------------------------------------------------
module lpmr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output lpmr_pkg::dp_cmd_t       cmd,
	input  lpmr_pkg::dp_status_t    stat
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_READ = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic accept;

	assign in_stall = (state_q != S_IDLE) || (out_valid_q && out_stall);
	assign accept   = in_valid && !in_stall;

	assign cmd.accept     = accept;
	assign cmd.read_phase = (state_q == S_READ);
	assign out_valid      = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept && stat.rx_op) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((accept && !stat.rx_op) || (state_q == S_READ)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ----- hdl/lpmr_dp.sv -----
// ----------------------------------------------------------------------------
// lpmr_dp
// Ring datapath: pointers, space and message counts, ring RAM, result register.
// ----------------------------------------------------------------------------
module lpmr_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  lpmr_pkg::in_item_t                    in_data,
	output lpmr_pkg::out_item_t                   out_data,
	input  logic                                  cfg_we,
	input  logic [lpmr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lpmr_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  lpmr_pkg::dp_cmd_t                     cmd,
	output lpmr_pkg::dp_status_t                  stat
);

	localparam int PTR_W  = lpmr_pkg::PTR_W;
	localparam int SIZE_W = lpmr_pkg::SIZE_W;
	localparam int SUM_W  = lpmr_pkg::SUM_W;

	logic [SIZE_W-1:0] ring_size_q;
	logic [7:0]        max_msg_q;
	logic [PTR_W-1:0]  wp_q, wp_n;
	logic [PTR_W-1:0]  rp_q, rp_n;
	logic [SIZE_W-1:0] free_q, free_n;
	logic [SIZE_W-1:0] complete_q, complete_n;
	logic [7:0]        send_rem_q, send_rem_n;
	logic [7:0]        recv_rem_q, recv_rem_n;
	logic [7:0]        recv_len_q;
	logic              sending_q, sending_n;
	logic              receiving_q, receiving_n;
	logic              rd_len_q, rd_len_n;
	logic              rd_val_q, rd_val_n;

	lpmr_pkg::out_item_t res;
	lpmr_pkg::out_item_t out_q;

	logic              ram_we;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [7:0]        ram_rdata;
	logic [SUM_W-1:0]  need;
	logic [SUM_W-1:0]  refill;

	assign stat.rx_op = in_data.opcode[1];
	assign out_data   = out_q;

	assign need   = SUM_W'(in_data.message_length) + 1'b1;
	assign refill = SUM_W'(free_q) + SUM_W'(recv_len_q) + 1'b1;

	always_comb begin
		res         = '0;
		res.status  = lpmr_pkg::STAT_OK;
		ram_we      = 1'b0;
		ram_wdata   = in_data.data_byte;
		ram_re      = 1'b0;
		wp_n        = wp_q;
		rp_n        = rp_q;
		free_n      = free_q;
		complete_n  = complete_q;
		send_rem_n  = send_rem_q;
		recv_rem_n  = recv_rem_q;
		sending_n   = sending_q;
		receiving_n = receiving_q;
		rd_len_n    = 1'b0;
		rd_val_n    = 1'b0;
		case (in_data.opcode)
			lpmr_pkg::OP_SEND_START: begin
				if (sending_q) begin
					res.status = lpmr_pkg::STAT_SEQUENCE;
				end else if (in_data.message_length == 8'd0 ||
					in_data.message_length > max_msg_q) begin
					res.status = lpmr_pkg::STAT_BAD_LEN;
				end else if (need > SUM_W'(free_q)) begin
					res.status = lpmr_pkg::STAT_NO_SPACE;
				end else begin
					ram_we     = 1'b1;
					ram_wdata  = in_data.message_length;
					wp_n       = lpmr_pkg::next_pos(wp_q, ring_size_q);
					free_n     = SIZE_W'(SUM_W'(free_q) - need);
					send_rem_n = in_data.message_length;
					sending_n  = 1'b1;
				end
			end
			lpmr_pkg::OP_SEND_BYTE: begin
				if (!sending_q || send_rem_q == 8'd0) begin
					res.status = lpmr_pkg::STAT_SEQUENCE;
				end else begin
					ram_we     = 1'b1;
					wp_n       = lpmr_pkg::next_pos(wp_q, ring_size_q);
					send_rem_n = send_rem_q - 8'd1;
					if (send_rem_q == 8'd1) begin
						sending_n       = 1'b0;
						complete_n      = complete_q + 1'b1;
						res.notify_sent = 1'b1;
					end
				end
			end
			lpmr_pkg::OP_RECV_START: begin
				if (receiving_q) begin
					res.status = lpmr_pkg::STAT_SEQUENCE;
				end else if (complete_q == '0) begin
					res.status = lpmr_pkg::STAT_EMPTY;
				end else begin
					ram_re      = 1'b1;
					rp_n        = lpmr_pkg::next_pos(rp_q, ring_size_q);
					receiving_n = 1'b1;
					rd_len_n    = 1'b1;
				end
			end
			default: begin
				if (!receiving_q) begin
					res.status = lpmr_pkg::STAT_SEQUENCE;
				end else begin
					if (recv_rem_q != 8'd0) begin
						ram_re     = 1'b1;
						rp_n       = lpmr_pkg::next_pos(rp_q, ring_size_q);
						rd_val_n   = 1'b1;
						recv_rem_n = recv_rem_q - 8'd1;
					end
					if (recv_rem_q <= 8'd1) begin
						res.last_byte       = 1'b1;
						res.notify_received = 1'b1;
						receiving_n         = 1'b0;
						free_n = (refill > SUM_W'(ring_size_q)) ? ring_size_q
							: SIZE_W'(refill);
						if (complete_q != '0) begin
							complete_n = complete_q - 1'b1;
						end
					end
				end
			end
		endcase
	end

	lpmr_ram #(
		.WIDTH (8),
		.DEPTH (lpmr_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we && cmd.accept),
		.waddr (wp_q),
		.wdata (ram_wdata),
		.re    (ram_re && cmd.accept),
		.raddr (rp_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_size_q <= lpmr_pkg::RESET_SIZE;
			max_msg_q   <= lpmr_pkg::RESET_MAX_MSG;
			wp_q        <= '0;
			rp_q        <= '0;
			free_q      <= lpmr_pkg::RESET_SIZE;
			complete_q  <= '0;
			send_rem_q  <= '0;
			recv_rem_q  <= '0;
			recv_len_q  <= '0;
			sending_q   <= 1'b0;
			receiving_q <= 1'b0;
			rd_len_q    <= 1'b0;
			rd_val_q    <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == lpmr_pkg::REG_RING_SIZE) begin
				ring_size_q <= lpmr_pkg::clamp_size(cfg_data);
				wp_q        <= '0;
				rp_q        <= '0;
				free_q      <= lpmr_pkg::clamp_size(cfg_data);
				complete_q  <= '0;
				send_rem_q  <= '0;
				recv_rem_q  <= '0;
				recv_len_q  <= '0;
				sending_q   <= 1'b0;
				receiving_q <= 1'b0;
			end else if (cfg_index == lpmr_pkg::REG_MAX_MSG) begin
				max_msg_q <= cfg_data[7:0];
			end
		end else if (cmd.accept) begin
			wp_q        <= wp_n;
			rp_q        <= rp_n;
			free_q      <= free_n;
			complete_q  <= complete_n;
			send_rem_q  <= send_rem_n;
			recv_rem_q  <= recv_rem_n;
			sending_q   <= sending_n;
			receiving_q <= receiving_n;
			rd_len_q    <= rd_len_n;
			rd_val_q    <= rd_val_n;
		end else if (cmd.read_phase && rd_len_q) begin
			recv_len_q <= ram_rdata;
			recv_rem_q <= ram_rdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			out_q <= res;
		end else if (cmd.read_phase && (rd_len_q || rd_val_q)) begin
			out_q.read_value <= ram_rdata;
		end
	end

endmodule

// ----- hdl/length_prefixed_message_ring_core.sv -----
// ----------------------------------------------------------------------------
// length_prefixed_message_ring_core
// Mailbox keeping length-prefixed messages in a wrapping byte ring.
//
//   channel   handshake              payload
//   in        in_valid / in_stall    in_data    (opcode, length, data byte)
//   out       out_valid / out_stall  out_data   (status, value, flags)
//   cfg       cfg_we                 cfg_index, cfg_data
//
// send opcodes register their result on acceptance; receive opcodes pass
// through a read state, set by the registered read port of the ring ram.
// arst_n empties the ring; ring contents are not cleared, no clearing pass.
// a new input transfer is taken while the result register drains in the
// same cycle; a stalled result holds the input side.
// ----------------------------------------------------------------------------
module length_prefixed_message_ring_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  lpmr_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output lpmr_pkg::out_item_t               out_data,
	input  logic                              cfg_we,
	input  logic [lpmr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [lpmr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	lpmr_pkg::dp_cmd_t    cmd;
	lpmr_pkg::dp_status_t stat;

	lpmr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	lpmr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
